@@ rtl/tlep_pkg.sv @@
// tlep_pkg: shared payload types, character codes and candidate name table
// for the trace line event parser. No dependencies.
`default_nettype none

package tlep_pkg;

  // One input transfer: a text byte, or the end-of-line marker
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  // One result transfer, produced only for an end-of-line item
  typedef struct packed {
    logic        [2:0]  event_kind;
    logic signed [31:0] stamp_seconds;
    logic signed [31:0] stamp_micros;
  } out_item_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PAREN = 8'h28;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Line layout
  localparam logic [2:0] DOT_RUN_LEN = 3'd4;
  localparam logic [2:0] SKIP_LEN    = 3'd6;

  // Magnitude saturation point (2^31)
  localparam logic [31:0] SAT_MAG = 32'h8000_0000;
  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;

  // Event kinds: enter = 2k+1, exit = 2k+2 for candidate k
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam int unsigned NUM_CAND = 3;

  // Candidate name lengths: sendto, recvmsg, select
  localparam logic [3:0] CAND_LEN [NUM_CAND] = '{4'd6, 4'd7, 4'd6};

  // Character p of candidate k (left-aligned in an 8-byte word)
  function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] p);
    logic [63:0] word;
    logic [2:0]  slot;
    word = 64'h0;
    slot = 3'd7 - p;
    unique case (k)
      2'd0:    word = {"sendto", 16'h0};
      2'd1:    word = {"recvmsg", 8'h0};
      2'd2:    word = {"select", 16'h0};
      default: word = 64'h0;
    endcase
    return word[{slot, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/tlep_parse.sv @@
// tlep_parse: parse phase state and per-character next-state logic for one
// trace line. Depends on tlep_pkg.
`default_nettype none

module tlep_parse #(
  parameter int unsigned MAX_NAME_LEN = 64,
  parameter int unsigned NAME_LEN_W   = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire tlep_pkg::in_item_t  item_i,
  output      tlep_pkg::out_item_t result_o
);
  import tlep_pkg::*;

  typedef enum logic [2:0] {
    PH_DOTS,
    PH_SEC,
    PH_USEC,
    PH_SKIP,
    PH_NAME,
    PH_DONE
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [2:0]            dot_run_q, dot_run_d;
  logic [31:0]           sec_q, sec_d;
  logic [31:0]           usec_q, usec_d;
  logic                  neg_q, neg_d;
  logic                  num_started_q, num_started_d;
  logic [2:0]            skip_q, skip_d;
  logic [NAME_LEN_W-1:0] name_cnt_q, name_cnt_d;
  logic [NUM_CAND-1:0]   match_q, match_d;
  logic [2:0]            kind_q, kind_d;

  // Apply sign to a saturated magnitude, clamping to the signed range
  function automatic logic [31:0] signed_result(input logic [31:0] mag, input logic neg);
    if (neg) begin
      return (mag >= SAT_MAG) ? SAT_MAG : (32'd0 - mag);
    end
    return (mag > MAX_POS) ? MAX_POS : mag;
  endfunction

  // First surviving candidate whose length matches gives the event kind
  function automatic logic [2:0] name_kind(input logic [NUM_CAND-1:0] flags,
                                           input logic [NAME_LEN_W-1:0] len,
                                           input logic enter);
    logic [2:0] kind;
    kind = KIND_NONE;
    for (int k = NUM_CAND - 1; k >= 0; k--) begin
      if (flags[k] && (len == NAME_LEN_W'(CAND_LEN[k]))) begin
        kind = 3'(2 * k) + (enter ? 3'd1 : 3'd2);
      end
    end
    return kind;
  endfunction

  // Character classes
  logic [7:0] c;
  logic       is_digit, is_blank, is_sign, num_end, name_term;
  assign c         = item_i.char_code;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_blank  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
  assign num_end   = !is_digit && !(!num_started_q && (is_blank || is_sign));
  assign name_term = (c == CH_SPACE) || (c == CH_PAREN) || (c == CH_NUL);

  // Shared multiply-by-ten accumulate with saturation at 2^31
  logic [31:0] acc_sel, acc_sat;
  logic [35:0] acc_wide, acc_next;
  logic [3:0]  digit;
  assign acc_sel  = (phase_q == PH_SEC) ? sec_q : usec_q;
  assign digit    = 4'(c - CH_ZERO);
  assign acc_wide = {4'b0, acc_sel};
  assign acc_next = (acc_wide << 3) + (acc_wide << 1) + 36'(digit);
  assign acc_sat  = (acc_next > 36'(SAT_MAG)) ? SAT_MAG : acc_next[31:0];

  // Candidate comparison for the next name character
  logic [NUM_CAND-1:0] match_upd;
  always_comb begin
    match_upd = match_q;
    for (int k = 0; k < NUM_CAND; k++) begin
      if ((name_cnt_q >= NAME_LEN_W'(CAND_LEN[k])) ||
          (cand_char(2'(k), name_cnt_q[2:0]) != c)) begin
        match_upd[k] = 1'b0;
      end
    end
  end

  // Result fields from the current state at end of line
  logic [31:0] res_sec, res_usec;
  logic [2:0]  res_kind;
  always_comb begin
    res_sec  = 32'd0;
    res_usec = 32'd0;
    res_kind = KIND_NONE;
    unique case (phase_q)
      PH_DOTS: ;
      PH_SEC:  res_sec = signed_result(sec_q, neg_q);
      PH_USEC: begin
        res_sec  = sec_q;
        res_usec = signed_result(usec_q, neg_q);
      end
      PH_NAME: begin
        res_sec  = sec_q;
        res_usec = usec_q;
        res_kind = name_kind(match_q, name_cnt_q, 1'b0);
      end
      PH_DONE: begin
        res_sec  = sec_q;
        res_usec = usec_q;
        res_kind = kind_q;
      end
      default: begin
        res_sec  = sec_q;
        res_usec = usec_q;
      end
    endcase
  end

  assign result_o = {res_kind, res_sec, res_usec};

  // Next-state logic for one character
  always_comb begin
    phase_d       = phase_q;
    dot_run_d     = dot_run_q;
    sec_d         = sec_q;
    usec_d        = usec_q;
    neg_d         = neg_q;
    num_started_d = num_started_q;
    skip_d        = skip_q;
    name_cnt_d    = name_cnt_q;
    match_d       = match_q;
    kind_d        = kind_q;
    if (item_i.line_end) begin
      // clear for the next line
      phase_d       = PH_DOTS;
      dot_run_d     = 3'd0;
      sec_d         = 32'd0;
      usec_d        = 32'd0;
      neg_d         = 1'b0;
      num_started_d = 1'b0;
      skip_d        = 3'd0;
      name_cnt_d    = '0;
      match_d       = '1;
      kind_d        = KIND_NONE;
    end else begin
      unique case (phase_q)
        PH_DOTS: begin
          if (c == CH_DOT) begin
            dot_run_d = dot_run_q + 3'd1;
            if (dot_run_d >= DOT_RUN_LEN) begin
              phase_d       = PH_SEC;
              num_started_d = 1'b0;
              neg_d         = 1'b0;
            end
          end else begin
            dot_run_d = 3'd0;
          end
        end
        PH_SEC, PH_USEC: begin
          if (is_digit) begin
            if (phase_q == PH_SEC) sec_d = acc_sat;
            else                   usec_d = acc_sat;
            num_started_d = 1'b1;
          end else if (!num_end) begin
            if (is_sign) begin
              neg_d         = (c == CH_MINUS);
              num_started_d = 1'b1;
            end
          end else if (phase_q == PH_SEC) begin
            sec_d         = signed_result(sec_q, neg_q);
            neg_d         = 1'b0;
            num_started_d = 1'b0;
            phase_d       = PH_USEC;
          end else begin
            usec_d  = signed_result(usec_q, neg_q);
            neg_d   = 1'b0;
            skip_d  = 3'd1;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q + 3'd1;
          if (skip_d >= SKIP_LEN) phase_d = PH_NAME;
        end
        PH_NAME: begin
          if (name_term) begin
            kind_d  = name_kind(match_q, name_cnt_q, c == CH_PAREN);
            phase_d = PH_DONE;
          end else if (name_cnt_q < NAME_LEN_W'(MAX_NAME_LEN)) begin
            match_d    = match_upd;
            name_cnt_d = name_cnt_q + NAME_LEN_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_DOTS;
      dot_run_q     <= 3'd0;
      sec_q         <= 32'd0;
      usec_q        <= 32'd0;
      neg_q         <= 1'b0;
      num_started_q <= 1'b0;
      skip_q        <= 3'd0;
      name_cnt_q    <= '0;
      match_q       <= '1;
      kind_q        <= KIND_NONE;
    end else if (step_i) begin
      phase_q       <= phase_d;
      dot_run_q     <= dot_run_d;
      sec_q         <= sec_d;
      usec_q        <= usec_d;
      neg_q         <= neg_d;
      num_started_q <= num_started_d;
      skip_q        <= skip_d;
      name_cnt_q    <= name_cnt_d;
      match_q       <= match_d;
      kind_q        <= kind_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/trace_line_event_parser_core.sv @@
// Trace line event parser, top level: input register, parser, result register.
// A result is offered on out_valid_o from the result register, loaded when its
// end-of-line item leaves the input register. Throughput: one character per
// cycle, set by the single parser step between the two registers.
// A held result stalls only a following end-of-line item. Reset (asynchronous,
// active low) empties both registers and returns the parser to the dot search.
// Depends on tlep_pkg and tlep_parse.
`default_nettype none

module trace_line_event_parser_core #(
  parameter int unsigned MAX_NAME_LEN = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire tlep_pkg::in_item_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      tlep_pkg::out_item_t out_data_o
);
  import tlep_pkg::*;

  localparam int unsigned NAME_LEN_W = $clog2(MAX_NAME_LEN + 1);

  logic      stage_valid_q;
  in_item_t  stage_data_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  out_item_t result;
  logic      stage_fire;

  // Only an end-of-line item needs room in the result register
  assign stage_fire = stage_valid_q &&
                      (!stage_data_q.line_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || stage_fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stage_data_q <= in_data_i;
    end
  end

  tlep_parse #(
    .MAX_NAME_LEN(MAX_NAME_LEN),
    .NAME_LEN_W  (NAME_LEN_W)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (stage_fire),
    .item_i  (stage_data_q),
    .result_o(result)
  );

  // Result register
  logic out_load;
  assign out_load = stage_fire && stage_data_q.line_end;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/tlep_checker.sv @@
// tlep_checker: port-level assertions for the trace line event parser, bound
// to trace_line_event_parser_core. Depends on tlep_pkg.
`default_nettype none

module tlep_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire tlep_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire tlep_pkg::out_item_t out_data_o
);

  // A result only appears after an end-of-line transfer
  a_result_from_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_data_i.line_end, 2))
    else $error("result appeared without a matching end-of-line transfer");

  // With no result held the block always takes input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while no result is held");

  // Event kind code seven is never produced
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.event_kind != 3'd7))
    else $error("event kind out of range");

  // A stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result dropped or changed");

endmodule

bind trace_line_event_parser_core tlep_checker u_tlep_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

@@ verif/trace_line_event_parser_core_tb.sv @@
// trace_line_event_parser_core_tb: self-checking bench for the trace line event parser.
// Streams whole trace lines, models the parser per character and checks every
// end-of-line result. Depends on tlep_pkg and trace_line_event_parser_core.

module trace_line_event_parser_core_tb;
  import tlep_pkg::*;

  localparam int NAME_MAX    = 64;
  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  // Event kind quoted in the directed table
  localparam logic [2:0] KIND_SELECT_EXIT = 3'd6;

  typedef enum logic [2:0] {
    SEEK_DOTS, GET_SECONDS, GET_MICROS, SKIP_COLS, GET_NAME, NAME_DONE
  } parse_phase_e;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t res;
  } stim_t;

  typedef struct {
    string      text;
    logic [7:0] end_char;
    bit         fixed;
    out_item_t  res;
  } line_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  always #5 clk_i = ~clk_i;

  trace_line_event_parser_core #(
    .MAX_NAME_LEN(NAME_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Parser model state
  parse_phase_e ph;
  logic [2:0]   dot_cnt;
  logic [31:0]  sec_mag;
  logic [31:0]  usec_mag;
  bit           is_neg;
  bit           num_started;
  logic [2:0]   skip_cnt;
  logic [6:0]   name_cnt;
  logic [2:0]   name_hits;
  logic [2:0]   held_kind;
  string        cand_name [3] = '{"sendto", "recvmsg", "select"};

  // Stimulus, line under construction and results still owed by the block
  stim_t       stim_q [$];
  logic [7:0]  line_buf [$];
  out_item_t   due_results [$];
  string       big_numbers [4] = '{"2147483647", "2147483648", "2147483649",
                                   "99999999999999"};

  int errors       = 0;
  int lines_sent   = 0;
  int results_seen = 0;
  int events_seen  = 0;
  int cycles       = 0;
  bit in_calm      = 1'b0;
  bit out_calm     = 1'b0;

  // ---------------------------------------------------------------- model
  task automatic clear_parser();
    ph          = SEEK_DOTS;
    dot_cnt     = '0;
    sec_mag     = '0;
    usec_mag    = '0;
    is_neg      = 1'b0;
    num_started = 1'b0;
    skip_cnt    = '0;
    name_cnt    = '0;
    name_hits   = '1;
    held_kind   = KIND_NONE;
  endtask

  function automatic logic [31:0] clamp_signed(input logic [31:0] mag, input bit neg);
    if (neg) begin
      return (mag >= SAT_MAG) ? SAT_MAG : -mag;
    end
    return (mag > MAX_POS) ? MAX_POS : mag;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // One character of a number; ended is set by the character that closes it
  task automatic number_step(inout logic [31:0] acc, input logic [7:0] c, output bit ended);
    logic [63:0] t;
    ended = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
      acc = (t > {32'd0, SAT_MAG}) ? SAT_MAG : t[31:0];
      num_started = 1'b1;
    end else if (!num_started && (c == CH_PLUS || c == CH_MINUS)) begin
      is_neg = (c == CH_MINUS);
      num_started = 1'b1;
    end else begin
      ended = num_started || !is_blank(c);
    end
  endtask

  function automatic logic [2:0] kind_of(input bit enter);
    for (int k = 0; k < 3; k++) begin
      if (name_hits[k] && name_cnt == cand_name[k].len()) begin
        return 3'(2 * k + (enter ? 1 : 2));
      end
    end
    return KIND_NONE;
  endfunction

  task automatic name_step(input logic [7:0] c);
    if (name_cnt < NAME_MAX) begin
      for (int k = 0; k < 3; k++) begin
        if (name_cnt >= cand_name[k].len() || cand_name[k][name_cnt] != c) begin
          name_hits[k] = 1'b0;
        end
      end
      name_cnt = name_cnt + 1;
    end
  endtask

  // Advance the model by one accepted item; emits marks an end-of-line result
  task automatic parse_item(input in_item_t it, output bit emits, output out_item_t res);
    bit ended;
    emits = 1'b0;
    res   = '0;
    if (it.line_end) begin
      emits = 1'b1;
      case (ph)
        SEEK_DOTS: begin
        end
        GET_SECONDS: begin
          res.stamp_seconds = clamp_signed(sec_mag, is_neg);
        end
        GET_MICROS: begin
          res.stamp_seconds = sec_mag;
          res.stamp_micros  = clamp_signed(usec_mag, is_neg);
        end
        default: begin
          res.stamp_seconds = sec_mag;
          res.stamp_micros  = usec_mag;
        end
      endcase
      if (ph == GET_NAME) begin
        res.event_kind = kind_of(1'b0);
      end else if (ph == NAME_DONE) begin
        res.event_kind = held_kind;
      end
      clear_parser();
    end else begin
      case (ph)
        SEEK_DOTS: begin
          if (it.char_code == CH_DOT) begin
            dot_cnt = dot_cnt + 1;
            if (dot_cnt >= DOT_RUN_LEN) begin
              ph          = GET_SECONDS;
              num_started = 1'b0;
              is_neg      = 1'b0;
            end
          end else begin
            dot_cnt = '0;
          end
        end
        GET_SECONDS: begin
          number_step(sec_mag, it.char_code, ended);
          if (ended) begin
            sec_mag     = clamp_signed(sec_mag, is_neg);
            is_neg      = 1'b0;
            num_started = 1'b0;
            ph          = GET_MICROS;
          end
        end
        GET_MICROS: begin
          number_step(usec_mag, it.char_code, ended);
          if (ended) begin
            usec_mag = clamp_signed(usec_mag, is_neg);
            is_neg   = 1'b0;
            skip_cnt = 3'd1;
            ph       = SKIP_COLS;
          end
        end
        SKIP_COLS: begin
          skip_cnt = skip_cnt + 1;
          if (skip_cnt >= SKIP_LEN) ph = GET_NAME;
        end
        GET_NAME: begin
          if (it.char_code == CH_SPACE || it.char_code == CH_PAREN || it.char_code == CH_NUL) begin
            held_kind = kind_of(it.char_code == CH_PAREN);
            ph        = NAME_DONE;
          end else begin
            name_step(it.char_code);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  // ------------------------------------------------------------ stimulus
  task automatic push_char(input logic [7:0] c);
    stim_t s;
    s.item.char_code = c;
    s.item.line_end  = 1'b0;
    s.fixed          = 1'b0;
    s.res            = '0;
    stim_q.push_back(s);
  endtask

  task automatic push_end(input logic [7:0] c, input bit fixed, input out_item_t res);
    stim_t s;
    s.item.char_code = c;
    s.item.line_end  = 1'b1;
    s.fixed          = fixed;
    s.res            = res;
    stim_q.push_back(s);
  endtask

  task automatic buf_text(input string t);
    for (int i = 0; i < t.len(); i++) line_buf.push_back(t[i]);
  endtask

  function automatic logic [7:0] any_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] lower_letter();
    return 8'($urandom_range(97, 122));
  endfunction

  // Blanks, optional sign, then digits; sometimes none, sometimes huge
  task automatic buf_number();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(any_blank());
    end
    case ($urandom_range(0, 5))
      0:       line_buf.push_back(CH_PLUS);
      1:       line_buf.push_back(CH_MINUS);
      default: begin
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      buf_text(big_numbers[$urandom_range(0, 3)]);
    end else begin
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 7);
      repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // Call name: mostly a candidate, also near misses, random words, over-long names
  task automatic buf_name();
    int    pick;
    int    k;
    string nm;
    pick = $urandom_range(0, 19);
    k    = $urandom_range(0, 2);
    nm   = cand_name[k];
    if (pick < 12) begin
      buf_text(nm);
    end else if (pick < 15) begin
      if ($urandom_range(0, 1)) begin
        buf_text(nm.substr(0, nm.len() - 2));
      end else begin
        buf_text(nm);
        line_buf.push_back(lower_letter());
      end
    end else if (pick < 19) begin
      repeat ($urandom_range(1, 10)) line_buf.push_back(lower_letter());
    end else begin
      buf_text(nm);
      repeat ($urandom_range(NAME_MAX - 8, NAME_MAX + 16)) line_buf.push_back(lower_letter());
    end
  endtask

  // One random line: well formed, cut short, or plain noise
  task automatic make_line();
    int style;
    int keep;
    int term;
    line_buf.delete();
    style = $urandom_range(0, 9);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) buf_text("...");
      line_buf.push_back(8'($urandom_range(32, 126)));
    end
    if (style == 0) begin
      repeat ($urandom_range(0, 24)) begin
        line_buf.push_back($urandom_range(0, 3) == 0 ? CH_DOT : 8'($urandom_range(0, 255)));
      end
    end else begin
      buf_text("....");
      buf_number();
      line_buf.push_back($urandom_range(0, 3) ? CH_DOT : 8'($urandom_range(0, 255)));
      buf_number();
      line_buf.push_back($urandom_range(0, 3) ? 8'h3A : 8'($urandom_range(0, 255)));
      repeat (5) line_buf.push_back(8'($urandom_range(32, 126)));
      buf_name();
      term = $urandom_range(0, 9);
      if (term < 4) begin
        line_buf.push_back(CH_PAREN);
      end else if (term < 7) begin
        line_buf.push_back(CH_SPACE);
      end else if (term == 7) begin
        line_buf.push_back(CH_NUL);
      end
      repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
      if (style == 1) begin
        keep = $urandom_range(0, line_buf.size() - 1);
        while (line_buf.size() > keep) void'(line_buf.pop_back());
      end
    end
    foreach (line_buf[i]) push_char(line_buf[i]);
    push_end(8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // ------------------------------------------------------------- checking
  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (got.event_kind != KIND_NONE) events_seen++;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: result with none expected: kind %0d sec %0d usec %0d", $time,
               got.event_kind, $signed(got.stamp_seconds), $signed(got.stamp_micros));
    end else begin
      want = due_results.pop_front();
      if (got.event_kind != want.event_kind) begin
        errors++;
        $display("%0t: event_kind expected %0d, got %0d", $time,
                 want.event_kind, got.event_kind);
      end
      if (got.stamp_seconds != want.stamp_seconds) begin
        errors++;
        $display("%0t: stamp_seconds expected %0d, got %0d", $time,
                 $signed(want.stamp_seconds), $signed(got.stamp_seconds));
      end
      if (got.stamp_micros != want.stamp_micros) begin
        errors++;
        $display("%0t: stamp_micros expected %0d, got %0d", $time,
                 $signed(want.stamp_micros), $signed(got.stamp_micros));
      end
    end
  endtask

  // Result side: random back-pressure before each transfer
  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 47) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_data_o);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: no progress, %0d results still due", $time, due_results.size());
      $display("trace_line_event_parser_core_tb failed");
      $finish;
    end
  end

  // Input side: directed lines, random lines, then drain and report
  initial begin
    line_row_t dir_rows [3];
    stim_t     s;
    bit        emits;
    out_item_t res;
    int        gap;

    // Empty line straight after reset, a bare negative seconds value, and a
    // full line that stops inside the name
    dir_rows[0] = '{"", 8'hFF, 1'b1, '{KIND_NONE, 32'sd0, 32'sd0}};
    dir_rows[1] = '{"....-9", 8'h00, 1'b1, '{KIND_NONE, -32'sd9, 32'sd0}};
    dir_rows[2] = '{"....1.2 12345select", 8'h5A, 1'b1,
                    '{KIND_SELECT_EXIT, 32'sd1, 32'sd2}};
    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].text.len(); i++) push_char(dir_rows[r].text[i]);
      push_end(dir_rows[r].end_char, dir_rows[r].fixed, dir_rows[r].res);
    end
    while (stim_q.size() < ITEM_TARGET) make_line();

    clear_parser();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_q[i]) begin
      s = stim_q[i];
      if ($urandom_range(0, 47) == 0) in_calm = !in_calm;
      gap = in_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= s.item;
      do @(posedge clk_i); while (!in_ready_o);
      parse_item(s.item, emits, res);
      if (emits) begin
        lines_sent++;
        due_results.push_back(s.fixed ? s.res : res);
      end
    end
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d character and end-of-line transfers over %0d lines.",
             stim_q.size(), lines_sent);
    $display("Checked %0d results, %0d carrying a call event; %0d errors.",
             results_seen, events_seen, errors);
    if (errors == 0) begin
      $display("trace_line_event_parser_core_tb passed");
    end else begin
      $display("trace_line_event_parser_core_tb failed");
    end
    $finish;
  end

endmodule
